// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers; clk and rst are taken from the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_RST(lbl, prop) lbl: assert property (@(posedge clk) disable iff (rst) prop) \
  else $error("assertion failed");

// checked on every edge
`define ASSERT_ALWAYS(lbl, prop) lbl: assert property (@(posedge clk) prop) \
  else $error("assertion failed");

`endif

// ===== hw/rtl/hlg_pkg.sv =====
package hlg_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IN_W      = FRAC_BITS + 4;
  localparam int LVL_W     = FRAC_BITS + 1;
  localparam int QP        = 30;
  localparam int SHIFT_P   = QP - FRAC_BITS;
  localparam int P_W       = QP + 1;
  localparam int S_W       = P_W + 1;
  localparam int K_W       = 27;
  localparam int ROOT_W    = 15;
  localparam int TERMS     = 12;

  typedef logic [LVL_W-1:0] lvl_t;

  localparam lvl_t ONE_F      = lvl_t'(1) << FRAC_BITS;
  localparam lvl_t SQRT_X_MAX = ONE_F / 12;
  localparam lvl_t SQR_X_MAX  = ONE_F >> 1;

  localparam logic [63:0] ONE_P   = 64'd1 << QP;
  localparam logic [63:0] CONST_A = 64'd192020225;
  localparam logic [63:0] CONST_B = ONE_P - 64'd4 * CONST_A;
  localparam logic [63:0] CONST_C = 64'd601199569;
  localparam logic [63:0] LN2_P   = 64'd744261118;
  localparam logic [63:0] CONST_K = (CONST_A * LN2_P + (ONE_P >> 1)) >> QP;
  localparam logic [63:0] CONST_D = CONST_C - CONST_K;

  // stage counts from the registered, clamped level to each path's output, and from acceptance to done
  localparam int LAT_LOG   = QP + 4;
  localparam int LAT_EXP   = 1 + 3 + QP + 1 + 3 * TERMS + 2;
  localparam int LAT_POW   = ROOT_W + 2;
  localparam int LAT_TOTAL = LAT_EXP + 2;

endpackage

// ===== hw/rtl/hlg_transfer_function.sv =====
// A result is strobed on done once its item has passed the input register x0, the
// inverse exp pipeline (the other paths are padded to match it) and sample_out.
// Throughput: one item per clock; busy is low except in and just after reset.
// Reset (rst, synchronous): clears inverse_mode and all in-flight items.
// The receiver cannot stall; each result is on sample_out for one cycle.
`include "assert_macros.svh"

module hlg_transfer_function (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [hlg_pkg::IN_W-1:0]    sample_in,
  output logic                               done,
  output hlg_pkg::lvl_t                      sample_out,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_data
);
  import hlg_pkg::*;

  localparam logic [1:0] SEG_SQRT = 2'd0;
  localparam logic [1:0] SEG_LOG  = 2'd1;
  localparam logic [1:0] SEG_SQR  = 2'd2;
  localparam logic [1:0] SEG_EXP  = 2'd3;

  localparam int PAD_LOG = LAT_EXP - LAT_LOG;
  localparam int PAD_POW = LAT_EXP - LAT_POW;

  logic               inverse_mode;
  logic               accept;
  logic [IN_W-2:0]    mag;
  lvl_t               xc, x0;
  logic [1:0]         seg;
  logic [LAT_EXP:0]   vld_sr;
  logic [1:0]         seg_sr [0:LAT_EXP];
  lvl_t               y_log, y_exp, y_sqrt, y_sqr, pow_sel, y_sel;
  lvl_t               log_dly [0:PAD_LOG-1];
  lvl_t               pow_dly [0:PAD_POW-1];

  assign accept    = start && !busy;
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b1;
      inverse_mode <= 1'b0;
    end else begin
      busy <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        inverse_mode <= cfg_data;
      end
    end
  end

  // clamp to [0,1] and pick the curve segment
  assign mag = sample_in[IN_W-2:0];
  assign xc  = sample_in[IN_W-1] ? '0 :
               (mag > (IN_W-1)'(ONE_F)) ? ONE_F : lvl_t'(mag);

  always_comb begin
    if (inverse_mode) begin
      seg = (xc <= SQR_X_MAX) ? SEG_SQR : SEG_EXP;
    end else begin
      seg = (xc <= SQRT_X_MAX) ? SEG_SQRT : SEG_LOG;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_sr <= '0;
      done   <= 1'b0;
    end else begin
      vld_sr <= {vld_sr[LAT_EXP-1:0], accept};
      done   <= vld_sr[LAT_EXP];
    end
  end

  always_ff @(posedge clk) begin
    x0        <= xc;
    seg_sr[0] <= seg;
    for (int i = 1; i <= LAT_EXP; i++) begin
      seg_sr[i] <= seg_sr[i-1];
    end
  end

  hlg_pow u_pow (
    .clk    (clk),
    .x      (x0),
    .y_sqrt (y_sqrt),
    .y_sqr  (y_sqr)
  );

  hlg_log u_log (
    .clk (clk),
    .x   (x0),
    .y   (y_log)
  );

  hlg_exp u_exp (
    .clk (clk),
    .x   (x0),
    .y   (y_exp)
  );

  // align the short paths with the exp path
  assign pow_sel = (seg_sr[LAT_POW] == SEG_SQR) ? y_sqr : y_sqrt;

  always_ff @(posedge clk) begin
    log_dly[0] <= y_log;
    for (int i = 1; i < PAD_LOG; i++) begin
      log_dly[i] <= log_dly[i-1];
    end
    pow_dly[0] <= pow_sel;
    for (int i = 1; i < PAD_POW; i++) begin
      pow_dly[i] <= pow_dly[i-1];
    end
  end

  always_comb begin
    case (seg_sr[LAT_EXP])
      SEG_SQRT, SEG_SQR: y_sel = pow_dly[PAD_POW-1];
      SEG_LOG:           y_sel = log_dly[PAD_LOG-1];
      default:           y_sel = y_exp;
    endcase
  end

  always_ff @(posedge clk) begin
    sample_out <= y_sel;
  end

  `ASSERT_RST(a_item_done, accept |-> ##(LAT_TOTAL) done)
  `ASSERT_RST(a_done_item, done |-> $past(accept, LAT_TOTAL))
  `ASSERT_RST(a_mode_hold, !$past(cfg_valid && cfg_ready) |-> $stable(inverse_mode))
  `ASSERT_ALWAYS(a_out_range, done |-> (sample_out <= ONE_F))

endmodule

// ===== hw/rtl/hlg_pow.sv =====
module hlg_pow (
  input  logic          clk,
  input  hlg_pkg::lvl_t x,
  output hlg_pkg::lvl_t y_sqrt,
  output hlg_pkg::lvl_t y_sqr
);
  import hlg_pkg::*;

  localparam int V_W = 2 * ROOT_W;
  localparam logic [17:0] DIV3_M = 18'(((1 << 17) + 2) / 3);

  logic [V_W-1:0]    vv [0:ROOT_W];
  logic [ROOT_W-1:0] rt [0:ROOT_W];
  logic [V_W:0]      rnd;

  logic [2*LVL_W-1:0] sq;
  logic [2*LVL_W:0]   num;
  logic [17:0]        tn;
  logic [35:0]        qd;
  lvl_t               sd [0:LAT_POW-2];

  // square root segment: 3x scaled, one result bit per stage
  always_ff @(posedge clk) begin
    if (x <= SQRT_X_MAX) begin
      vv[0] <= V_W'((32'(x) * 32'd3) << FRAC_BITS);
    end else begin
      vv[0] <= '0;
    end
    rt[0] <= '0;
  end

  for (genvar s = 1; s <= ROOT_W; s++) begin : g_root
    logic [ROOT_W-1:0] c;
    logic [V_W-1:0]    csq;
    assign c   = rt[s-1] | (ROOT_W'(1) << (ROOT_W - s));
    assign csq = V_W'(c) * V_W'(c);
    always_ff @(posedge clk) begin
      vv[s] <= vv[s-1];
      if (csq <= vv[s-1]) begin
        rt[s] <= c;
      end else begin
        rt[s] <= rt[s-1];
      end
    end
  end

  // round to nearest: bump when the remainder exceeds the root
  assign rnd = (V_W+1)'(rt[ROOT_W]) * (V_W+1)'(rt[ROOT_W]) + (V_W+1)'(rt[ROOT_W]);

  always_ff @(posedge clk) begin
    if ((V_W+1)'(vv[ROOT_W]) > rnd) begin
      y_sqrt <= lvl_t'(rt[ROOT_W]) + lvl_t'(1);
    end else begin
      y_sqrt <= lvl_t'(rt[ROOT_W]);
    end
  end

  // square segment: (2x^2 + 3*2^16) / (3*2^17)
  assign num = {sq, 1'b0} + (2*LVL_W+1)'(3 << FRAC_BITS);
  assign tn  = 18'(num >> (FRAC_BITS + 1));
  assign qd  = 36'(tn) * 36'(DIV3_M);

  always_ff @(posedge clk) begin
    sq    <= (2*LVL_W)'(x) * (2*LVL_W)'(x);
    sd[0] <= lvl_t'(qd >> 17);
    for (int i = 1; i <= LAT_POW - 2; i++) begin
      sd[i] <= sd[i-1];
    end
  end

  assign y_sqr = sd[LAT_POW-2];

endmodule

// ===== hw/rtl/hlg_log.sv =====
module hlg_log (
  input  logic          clk,
  input  hlg_pkg::lvl_t x,
  output hlg_pkg::lvl_t y
);
  import hlg_pkg::*;

  localparam int U_W = QP + 6;
  localparam logic [U_W-1:0] TWO_B = U_W'(64'd2 * CONST_B);
  localparam logic [K_W-1:0] KK    = K_W'(CONST_K);

  logic [U_W-1:0] u;
  logic [P_W-1:0] m0;
  logic [2:0]     e0;
  logic [P_W-1:0] m  [0:QP];
  logic [QP-1:0]  fr [0:QP];
  logic [2:0]     ex [0:QP];

  logic [K_W+QP-1:0] prod;
  logic [2:0]        ef;
  logic [31:0]       yp;
  logic [17:0]       yo;

  // u = 2*(12x - b) in Q30
  always_ff @(posedge clk) begin
    u <= ((U_W'(x) * U_W'(24)) << SHIFT_P) - TWO_B;
  end

  // normalize into [1,2)
  always_comb begin
    e0 = '0;
    for (int i = P_W; i < U_W; i++) begin
      if (u[i]) begin
        e0 = 3'(i - P_W + 1);
      end
    end
    m0 = P_W'(u >> e0);
  end

  always_ff @(posedge clk) begin
    m[0]  <= m0;
    ex[0] <= e0;
    fr[0] <= '0;
  end

  // one fraction bit of log2 per squaring
  for (genvar i = 1; i <= QP; i++) begin : g_sq
    logic [2*P_W-1:0] sqr;
    logic [P_W:0]     mm;
    assign sqr = (2*P_W)'(m[i-1]) * (2*P_W)'(m[i-1]);
    assign mm  = sqr[QP +: P_W+1];
    always_ff @(posedge clk) begin
      ex[i] <= ex[i-1];
      fr[i] <= fr[i-1] | (QP'(mm[P_W]) << (QP - i));
      if (mm[P_W]) begin
        m[i] <= mm[P_W:1];
      end else begin
        m[i] <= mm[P_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= (K_W+QP)'(KK) * (K_W+QP)'(fr[QP]);
    ef   <= ex[QP];
  end

  assign yp = 32'(KK) * 32'(ef)
            + 32'((prod + (K_W+QP)'(ONE_P >> 1)) >> QP)
            + 32'(CONST_D);
  assign yo = 18'((yp + 32'(1 << (SHIFT_P - 1))) >> SHIFT_P);

  always_ff @(posedge clk) begin
    if (yo > 18'(ONE_F)) begin
      y <= ONE_F;
    end else begin
      y <= lvl_t'(yo);
    end
  end

endmodule

// ===== hw/rtl/hlg_exp.sv =====
module hlg_exp (
  input  logic          clk,
  input  hlg_pkg::lvl_t x,
  output hlg_pkg::lvl_t y
);
  import hlg_pkg::*;

  localparam int W_W  = QP + 1;
  localparam int D_SH = SHIFT_P + 2;
  localparam logic [K_W-1:0] KK     = K_W'(CONST_K);
  localparam logic [63:0]    HALF_D = (64'd12 << SHIFT_P) >> 1;
  localparam logic [21:0]    DIV3_M = 22'(((1 << 21) + 2) / 3);

  logic [W_W-1:0] rq [0:3];
  logic [2:0]     qb [0:3];
  logic [K_W-1:0] rf [0:QP];
  logic [QP-1:0]  ff [0:QP];
  logic [2:0]     nf [0:QP];

  logic [P_W-1:0] term_s [0:TERMS];
  logic [S_W-1:0] sum_s  [0:TERMS];
  logic [QP-1:0]  g_s    [0:TERMS];
  logic [2:0]     n_s    [0:TERMS];

  logic [2*QP-1:0] gp;
  logic [38:0]     ev;
  logic [39:0]     sv;
  logic [23:0]     tq;
  logic [45:0]     qd;
  logic [24:0]     qy;

  always_ff @(posedge clk) begin
    rq[0] <= (W_W'(x) << SHIFT_P) - W_W'(CONST_D);
    qb[0] <= '0;
  end

  // integer part of (x - d) / k
  for (genvar s = 1; s <= 3; s++) begin : g_int
    logic [W_W-1:0] dv;
    assign dv = W_W'(KK) << (3 - s);
    always_ff @(posedge clk) begin
      qb[s] <= {qb[s-1][1:0], rq[s-1] >= dv};
      if (rq[s-1] >= dv) begin
        rq[s] <= rq[s-1] - dv;
      end else begin
        rq[s] <= rq[s-1];
      end
    end
  end

  assign rf[0] = K_W'(rq[3]);
  assign ff[0] = '0;
  assign nf[0] = qb[3];

  // fraction bits, one per stage
  for (genvar t = 1; t <= QP; t++) begin : g_frac
    logic [K_W:0] r2;
    assign r2 = {rf[t-1], 1'b0};
    always_ff @(posedge clk) begin
      nf[t] <= nf[t-1];
      ff[t] <= {ff[t-1][QP-2:0], r2 >= (K_W+1)'(KK)};
      if (r2 >= (K_W+1)'(KK)) begin
        rf[t] <= K_W'(r2 - (K_W+1)'(KK));
      end else begin
        rf[t] <= r2[K_W-1:0];
      end
    end
  end

  assign gp = (2*QP)'(ff[QP]) * (2*QP)'(LN2_P);

  always_ff @(posedge clk) begin
    g_s[0]    <= gp[QP +: QP];
    n_s[0]    <= nf[QP];
    term_s[0] <= P_W'(ONE_P);
    sum_s[0]  <= S_W'(ONE_P);
  end

  // Taylor terms of exp(g); terms past the eleventh are always zero
  for (genvar k = 1; k <= TERMS; k++) begin : g_term
    localparam logic [32:0] RK = 33'((64'd1 << 32) / k);
    logic [P_W+QP-1:0] pa;
    logic [QP-1:0]     ga, gb;
    logic [S_W-1:0]    sa, sb;
    logic [2:0]        na, nb;
    logic [P_W-1:0]    tt, tb, q0, rr, qf;
    logic [63:0]       qm;

    assign tt = pa[QP +: P_W];
    assign qm = 64'(tt) * 64'(RK);
    assign rr = tb - P_W'(q0 * P_W'(k));
    assign qf = q0 + P_W'(rr >= P_W'(k));

    always_ff @(posedge clk) begin
      pa <= (P_W+QP)'(term_s[k-1]) * (P_W+QP)'(g_s[k-1]);
      ga <= g_s[k-1];
      sa <= sum_s[k-1];
      na <= n_s[k-1];
      tb <= tt;
      q0 <= qm[32 +: P_W];
      gb <= ga;
      sb <= sa;
      nb <= na;
      term_s[k] <= qf;
      sum_s[k]  <= sb + S_W'(qf);
      g_s[k]    <= gb;
      n_s[k]    <= nb;
    end
  end

  assign ev = (39'(sum_s[TERMS]) << n_s[TERMS]) >> 1;
  assign sv = 40'(ev) + 40'(CONST_B) + 40'(HALF_D);
  assign qd = 46'(tq) * 46'(DIV3_M);
  assign qy = qd[21 +: 25];

  always_ff @(posedge clk) begin
    tq <= sv[D_SH +: 24];
    if (qy > 25'(ONE_F)) begin
      y <= ONE_F;
    end else begin
      y <= lvl_t'(qy);
    end
  end

endmodule
